@@ sv/kps_pkg.sv @@
// Package for the matrix keypad scanner.
// Holds the configuration struct, register indexes, scan phases and column drive patterns.
// No dependencies; kps_cfg, kps_core and the top level use it.
package kps_pkg;

	// Register indexes on the configuration write port.
	localparam logic [2:0] REG_ROWS_IN_USE    = 3'd0;
	localparam logic [2:0] REG_COLUMNS_IN_USE = 3'd1;
	localparam logic [2:0] REG_SETTLE_TICKS   = 3'd2;
	localparam logic [2:0] REG_KEY_MAP_LOW    = 3'd3;
	localparam logic [2:0] REG_KEY_MAP_HIGH   = 3'd4;

	localparam int unsigned CFG_INDEX_W = 3;
	localparam int unsigned CFG_DATA_W  = 64;

	// Reset values of the configuration registers.
	localparam logic [2:0]  RESET_ROWS_IN_USE    = 3'd4;
	localparam logic [2:0]  RESET_COLUMNS_IN_USE = 3'd3;
	localparam logic [15:0] RESET_SETTLE_TICKS   = 16'd10;

	// Scan phase: waiting for the column to settle, or holding a pressed key.
	typedef enum logic [0:0] {
		PHASE_SETTLING = 1'b0,
		PHASE_RELEASE  = 1'b1
	} phase_t;

	typedef struct packed {
		logic [2:0]  rows_in_use;
		logic [2:0]  columns_in_use;
		logic [15:0] settle_ticks;
		logic [63:0] key_map_low;
		logic [63:0] key_map_high;
	} cfg_t;

	// One result transaction.
	typedef struct packed {
		logic [3:0] column_drive;
		logic       key_valid;
		logic [7:0] key_code;
		logic [3:0] key_position;
	} result_t;

	// Active-low drive pattern for a column.
	function automatic logic [3:0] drive_pattern(input logic [1:0] col);
		logic [3:0] pat;
		case (col)
			2'd0:    pat = 4'b1110;
			2'd1:    pat = 4'b1101;
			2'd2:    pat = 4'b1011;
			default: pat = 4'b0111;
		endcase
		return pat;
	endfunction

endpackage

@@ sv/kps_if.sv @@
// Handshake interfaces for the keypad scanner channels.
// kps_tick_if carries the sampled row lines, kps_result_if the scan result.
// Depends on nothing; used by the top level.
interface kps_tick_if;
	logic       valid;
	logic       ready;
	logic [3:0] row_lines;

	modport source (output valid, output row_lines, input ready);
	modport sink   (input valid, input row_lines, output ready);
endinterface

interface kps_result_if;
	logic       valid;
	logic       ready;
	logic [3:0] column_drive;
	logic       key_valid;
	logic [7:0] key_code;
	logic [3:0] key_position;

	modport source (output valid, output column_drive, output key_valid,
		output key_code, output key_position, input ready);
	modport sink   (input valid, input column_drive, input key_valid,
		input key_code, input key_position, output ready);
endinterface

@@ sv/kps_cfg.sv @@
// Configuration register file of the keypad scanner.
// Takes writes from the plain write port and presents the registers as kps_pkg::cfg_t.
// Depends on kps_pkg.
module kps_cfg (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              write_enable,
	input  logic [kps_pkg::CFG_INDEX_W-1:0]   write_index,
	input  logic [kps_pkg::CFG_DATA_W-1:0]    write_data,
	output kps_pkg::cfg_t                     cfg
);

	kps_pkg::cfg_t cfg_q;

	// Register writes; indexes beyond the list are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rows_in_use    <= kps_pkg::RESET_ROWS_IN_USE;
			cfg_q.columns_in_use <= kps_pkg::RESET_COLUMNS_IN_USE;
			cfg_q.settle_ticks   <= kps_pkg::RESET_SETTLE_TICKS;
			cfg_q.key_map_low    <= 64'd0;
			cfg_q.key_map_high   <= 64'd0;
		end else if (write_enable) begin
			case (write_index)
				kps_pkg::REG_ROWS_IN_USE:    cfg_q.rows_in_use    <= write_data[2:0];
				kps_pkg::REG_COLUMNS_IN_USE: cfg_q.columns_in_use <= write_data[2:0];
				kps_pkg::REG_SETTLE_TICKS:   cfg_q.settle_ticks   <= write_data[15:0];
				kps_pkg::REG_KEY_MAP_LOW:    cfg_q.key_map_low    <= write_data;
				kps_pkg::REG_KEY_MAP_HIGH:   cfg_q.key_map_high   <= write_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ sv/kps_core.sv @@
// Scan state and per-tick step logic of the keypad scanner.
// Computes the result of one tick from the row lines and the scan state, and
// advances the state when the tick is processed. Depends on kps_pkg.
module kps_core (
	input  logic              clk,
	input  logic              arst_n,
	input  kps_pkg::cfg_t     cfg,
	input  logic              step,
	input  logic [3:0]        row_lines,
	output kps_pkg::result_t  res
);

	logic [1:0]      scan_column_q;
	kps_pkg::phase_t scan_phase_q;
	logic [15:0]     settle_count_q;
	logic [1:0]      held_row_q;

	logic [1:0]      scan_column_d;
	kps_pkg::phase_t scan_phase_d;
	logic [15:0]     settle_count_d;
	logic [1:0]      held_row_d;

	logic [3:0] row_mask;
	logic [3:0] pressed;
	logic [1:0] lowest;
	logic [2:0] cols_eff;
	logic [2:0] col_inc;
	logic [2:0] map_idx;
	logic [63:0] map_word;

	// Rows that are in use and read low; rows beyond the count read as released.
	always_comb begin
		case (cfg.rows_in_use)
			3'd0:    row_mask = 4'b0000;
			3'd1:    row_mask = 4'b0001;
			3'd2:    row_mask = 4'b0011;
			3'd3:    row_mask = 4'b0111;
			default: row_mask = 4'b1111;
		endcase
		pressed = ~row_lines & row_mask;
	end

	// Lowest-numbered pressed row wins.
	always_comb begin
		if (pressed[0])      lowest = 2'd0;
		else if (pressed[1]) lowest = 2'd1;
		else if (pressed[2]) lowest = 2'd2;
		else                 lowest = 2'd3;
	end

	// Effective column count is clamped to one through four.
	always_comb begin
		if (cfg.columns_in_use == 3'd0)     cols_eff = 3'd1;
		else if (cfg.columns_in_use > 3'd4) cols_eff = 3'd4;
		else                                cols_eff = cfg.columns_in_use;
		col_inc = {1'b0, scan_column_q} + 3'd1;
	end

	// Key map lookup for the held row and the current column.
	always_comb begin
		map_word = held_row_q[1] ? cfg.key_map_high : cfg.key_map_low;
		map_idx  = {held_row_q[0], scan_column_q};
	end

	// Next state and result of this tick.
	always_comb begin
		scan_column_d  = scan_column_q;
		scan_phase_d   = scan_phase_q;
		settle_count_d = settle_count_q;
		held_row_d     = held_row_q;

		res.column_drive = kps_pkg::drive_pattern(scan_column_q);
		res.key_valid    = 1'b0;
		res.key_code     = 8'd0;
		res.key_position = 4'd0;

		case (scan_phase_q)
			kps_pkg::PHASE_RELEASE: begin
				if (pressed == 4'd0) begin
					res.key_valid    = 1'b1;
					res.key_code     = map_word[{map_idx, 3'b000} +: 8];
					res.key_position = {held_row_q, scan_column_q};
					scan_column_d    = 2'd0;
					scan_phase_d     = kps_pkg::PHASE_SETTLING;
					settle_count_d   = 16'd0;
				end
			end
			default: begin
				if (settle_count_q < cfg.settle_ticks) begin
					settle_count_d = settle_count_q + 16'd1;
				end else if (pressed != 4'd0) begin
					held_row_d   = lowest;
					scan_phase_d = kps_pkg::PHASE_RELEASE;
				end else begin
					scan_column_d  = (col_inc >= cols_eff) ? 2'd0 : col_inc[1:0];
					settle_count_d = 16'd0;
				end
			end
		endcase
	end

	// Scan state registers, updated once per processed tick.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_column_q  <= 2'd0;
			scan_phase_q   <= kps_pkg::PHASE_SETTLING;
			settle_count_q <= 16'd0;
			held_row_q     <= 2'd0;
		end else if (step) begin
			scan_column_q  <= scan_column_d;
			scan_phase_q   <= scan_phase_d;
			settle_count_q <= settle_count_d;
			held_row_q     <= held_row_d;
		end
	end

endmodule

@@ sv/matrix_keypad_scanner.sv @@
// Top level of the matrix keypad scanner: input register, step logic, result register.
// Depends on kps_pkg, kps_if (kps_tick_if, kps_result_if), kps_cfg and kps_core.
//
//   channel       | direction | payload
//   --------------+-----------+-----------------------------------------------------
//   tick          | in        | row_lines[3:0]
//   result        | out       | column_drive[3:0], key_valid, key_code[7:0], key_position[3:0]
//   write port    | in        | write_enable, write_index[2:0], write_data[63:0]
//
// Each tick transaction yields exactly one result transaction; once accepted, it passes
// through the input register and then the result register on its way out.
// One tick is accepted every cycle while result.ready is high; kps_core keeps up with that.
// arst_n clears both pipeline valid bits, the scan state and the configuration registers.
// A stall on the result side fills the result register first, then the input register,
// and only then drops tick.ready; no transaction is lost or repeated.
module matrix_keypad_scanner (
	input  logic                             clk,
	input  logic                             arst_n,
	kps_tick_if.sink                         tick,
	kps_result_if.source                     result,
	input  logic                             write_enable,
	input  logic [kps_pkg::CFG_INDEX_W-1:0]  write_index,
	input  logic [kps_pkg::CFG_DATA_W-1:0]   write_data
);

	kps_pkg::cfg_t    cfg;
	kps_pkg::result_t res;

	logic       valid_s1;
	logic [3:0] row_lines_s1;
	logic       valid_s2;
	kps_pkg::result_t res_s2;
	logic       advance_s1;

	kps_cfg u_cfg (
		.clk          (clk),
		.arst_n       (arst_n),
		.write_enable (write_enable),
		.write_index  (write_index),
		.write_data   (write_data),
		.cfg          (cfg)
	);

	kps_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.step      (advance_s1),
		.row_lines (row_lines_s1),
		.res       (res)
	);

	// The input stage moves on when the result register is empty or being drained.
	assign advance_s1 = valid_s1 && (!valid_s2 || result.ready);
	assign tick.ready = !valid_s1 || advance_s1;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (tick.ready) begin
			valid_s1 <= tick.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (tick.valid && tick.ready) begin
			row_lines_s1 <= tick.row_lines;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance_s1) begin
			valid_s2 <= 1'b1;
		end else if (result.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1) begin
			res_s2 <= res;
		end
	end

	assign result.valid        = valid_s2;
	assign result.column_drive = res_s2.column_drive;
	assign result.key_valid    = res_s2.key_valid;
	assign result.key_code     = res_s2.key_code;
	assign result.key_position = res_s2.key_position;

endmodule

@@ sv/kps_chk.sv @@
// Port-level checker for the matrix keypad scanner, bound to the top level.
// Watches the result channel only. Depends on matrix_keypad_scanner.
module kps_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       valid,
	input logic       ready,
	input logic [3:0] column_drive,
	input logic       key_valid,
	input logic [7:0] key_code,
	input logic [3:0] key_position
);

	// Exactly one column is driven low in every result.
	a_one_column: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> $onehot(~column_drive))
		else $error("column_drive does not have exactly one low column");

	// A reported key lies in the column that was driven for that tick.
	a_key_column: assert property (@(posedge clk) disable iff (!arst_n)
		(valid && key_valid) |-> !column_drive[key_position[1:0]])
		else $error("key_position column differs from the driven column");

	// Without a key, code and position read as zero.
	a_no_key_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(valid && !key_valid) |-> (key_code == 8'd0 && key_position == 4'd0))
		else $error("key_code or key_position nonzero without key_valid");

	// A stalled result transaction holds its payload.
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid && !ready) |=> (valid && $stable(column_drive) && $stable(key_valid)
			&& $stable(key_code) && $stable(key_position)))
		else $error("result changed while stalled");

endmodule

bind matrix_keypad_scanner kps_chk u_kps_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.valid        (result.valid),
	.ready        (result.ready),
	.column_drive (result.column_drive),
	.key_valid    (result.key_valid),
	.key_code     (result.key_code),
	.key_position (result.key_position)
);
